>>> design/ipsa_pkg.sv
// Shared constants and helpers for the IPS/IPS32 patch stream applier.
package ipsa_pkg;

    localparam int ADDR_BITS = 32;
    localparam logic [32:0] ADDR_SPAN = 33'(1) << ADDR_BITS;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [1:0] REG_PROTECTED_SIZE = 2'd0;
    localparam logic [1:0] REG_LOAD_OFFSET    = 2'd1;
    localparam logic [1:0] REG_MAPPED_SIZE    = 2'd2;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_OFFS = 3'd2;
    localparam logic [2:0] PH_SIZE = 3'd3;
    localparam logic [2:0] PH_RLEN = 3'd4;
    localparam logic [2:0] PH_RVAL = 3'd5;
    localparam logic [2:0] PH_DATA = 3'd6;

    localparam logic [31:0] TAIL_IPS   = 32'h0045_4F46;
    localparam logic [31:0] TAIL_IPS32 = 32'h4545_4F46;

    localparam logic [2:0] HEAD_LAST = 3'd4;

    function automatic logic [7:0] magic_ips(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h48;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] magic_ips32(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h49;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h53;
            3'd3:    b = 8'h33;
            3'd4:    b = 8'h32;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> design/ips_patch_stream_applier_core.sv
// Top level of the IPS/IPS32 patch stream applier: byte parser and write command output.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one patch byte per transaction, with
//   i_file_start set on the first header byte of each file. The output channel
//   (o_valid/i_ready) carries write commands: byte write, fill run, end of patch
//   or header rejected. Most bytes (header, offset, size) produce no transaction.
//   Registers (protected size, load offset, mapped size) sit on an APB-style
//   port at byte addresses 0, 4 and 8; pready is always high.
//   A command appears on the outputs in the cycle after the byte that causes
//   it is accepted. Throughput: one byte per cycle while o_ready is high, set by
//   the single parse step between the parser state and the output register.
//   The output register is taken and refilled in the same cycle, so a stalled
//   receiver blocks input only while a command is waiting and i_ready is low.
//   Reset (synchronous, active low) clears the registers to zero, drops any
//   waiting command and returns the parser to idle, where bytes without
//   i_file_start are ignored.
module ips_patch_stream_applier_core
    import ipsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_patch_byte,
    input  logic        i_file_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [31:0] o_write_address,
    output logic [15:0] o_write_length,
    output logic [7:0]  o_write_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_protected_size;
    logic [31:0] r_load_offset;
    logic [31:0] r_mapped_size;

    logic [2:0]  r_phase, n_phase;
    logic        r_wide, n_wide;
    logic [2:0]  r_count, n_count;
    logic [31:0] r_shift, n_shift;
    logic [32:0] r_record_address, n_record_address;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_hit_ips, n_hit_ips;
    logic        r_hit_ips32, n_hit_ips32;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [31:0] r_out_address;
    logic [15:0] r_out_length;
    logic [7:0]  r_out_data;

    logic        n_emit;
    logic [1:0]  n_kind;
    logic [31:0] n_address;
    logic [15:0] n_length;

    logic        in_fire;
    logic        cfg_write;

    logic [2:0]  h_phase;
    logic [2:0]  h_count;
    logic        h_hit_ips;
    logic        h_hit_ips32;

    logic [32:0] lim;
    logic [32:0] prot_x;
    logic [32:0] load_x;

    logic [32:0] f_end;
    logic        f_below;
    logic        f_drop;
    logic [32:0] f_o2;
    logic [32:0] f_trim;
    logic [15:0] f_len2;
    logic [32:0] f_a;
    logic [32:0] f_rem;
    logic [15:0] f_len3;
    logic        f_emit;

    logic [32:0] d_a;
    logic        d_emit;
    logic [15:0] d_left;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_fire   = i_valid && o_ready;
    assign o_ready   = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protected_size <= '0;
            r_load_offset    <= '0;
            r_mapped_size    <= '0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_PROTECTED_SIZE: r_protected_size <= pwdata;
                REG_LOAD_OFFSET:    r_load_offset    <= pwdata;
                REG_MAPPED_SIZE:    r_mapped_size    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PROTECTED_SIZE: prdata = r_protected_size;
            REG_LOAD_OFFSET:    prdata = r_load_offset;
            REG_MAPPED_SIZE:    prdata = r_mapped_size;
            default:            prdata = '0;
        endcase
    end

    assign prot_x = {1'b0, r_protected_size};
    assign load_x = {1'b0, r_load_offset};
    assign lim    = ({1'b0, r_mapped_size} < ADDR_SPAN) ? {1'b0, r_mapped_size} : ADDR_SPAN;

    assign f_end   = r_record_address + {17'd0, r_bytes_left};
    assign f_below = r_record_address < prot_x;
    assign f_drop  = f_below && !(f_end > prot_x);
    assign f_o2    = f_below ? prot_x : r_record_address;
    assign f_trim  = f_end - prot_x;
    assign f_len2  = f_below ? f_trim[15:0] : r_bytes_left;
    assign f_a     = f_o2 - load_x;
    assign f_rem   = lim - f_a;
    assign f_len3  = ({17'd0, f_len2} > f_rem) ? f_rem[15:0] : f_len2;
    assign f_emit  = !f_drop && !(f_o2 < load_x) && !(f_a >= lim) && (f_len3 != 16'd0);

    assign d_a    = r_record_address - load_x;
    assign d_emit = !(r_record_address < prot_x) && !(r_record_address < load_x)
                    && (d_a < lim);
    assign d_left = r_bytes_left - 16'd1;

    assign h_phase     = i_file_start ? PH_HEAD : r_phase;
    assign h_count     = i_file_start ? 3'd0 : r_count;
    assign h_hit_ips   = i_file_start ? 1'b1 : r_hit_ips;
    assign h_hit_ips32 = i_file_start ? 1'b1 : r_hit_ips32;

    always_comb begin
        n_phase          = h_phase;
        n_wide           = r_wide;
        n_count          = h_count;
        n_shift          = r_shift;
        n_record_address = r_record_address;
        n_bytes_left     = r_bytes_left;
        n_hit_ips        = h_hit_ips;
        n_hit_ips32      = h_hit_ips32;
        n_emit           = 1'b0;
        n_kind           = KIND_WRITE;
        n_address        = '0;
        n_length         = '0;
        case (h_phase)
            PH_HEAD: begin
                n_hit_ips   = h_hit_ips && (i_patch_byte == magic_ips(h_count));
                n_hit_ips32 = h_hit_ips32 && (i_patch_byte == magic_ips32(h_count));
                n_count     = h_count + 3'd1;
                if (h_count == HEAD_LAST) begin
                    if ((!n_hit_ips && !n_hit_ips32) || (r_load_offset > r_protected_size)) begin
                        n_phase = PH_IDLE;
                        n_emit  = 1'b1;
                        n_kind  = KIND_REJECT;
                    end else begin
                        n_wide  = n_hit_ips32;
                        n_phase = PH_OFFS;
                        n_count = 3'd0;
                        n_shift = '0;
                    end
                end
            end
            PH_OFFS: begin
                n_shift = {r_shift[23:0], i_patch_byte};
                n_count = r_count + 3'd1;
                if (n_count == (r_wide ? 3'd4 : 3'd3)) begin
                    if (n_shift == (r_wide ? TAIL_IPS32 : TAIL_IPS)) begin
                        n_phase = PH_IDLE;
                        n_emit  = 1'b1;
                        n_kind  = KIND_END;
                    end else begin
                        n_record_address = {1'b0, n_shift};
                        n_phase          = PH_SIZE;
                        n_count          = 3'd0;
                        n_bytes_left     = '0;
                    end
                end
            end
            PH_SIZE, PH_RLEN: begin
                n_bytes_left = {r_bytes_left[7:0], i_patch_byte};
                n_count      = r_count + 3'd1;
                if (n_count == 3'd2) begin
                    n_count = 3'd0;
                    if (r_phase == PH_RLEN) begin
                        n_phase = PH_RVAL;
                    end else begin
                        n_phase = (n_bytes_left == 16'd0) ? PH_RLEN : PH_DATA;
                    end
                end
            end
            PH_RVAL: begin
                n_phase   = PH_OFFS;
                n_count   = 3'd0;
                n_shift   = '0;
                n_emit    = f_emit;
                n_kind    = KIND_FILL;
                n_address = f_a[31:0];
                n_length  = f_len3;
            end
            PH_DATA: begin
                n_record_address = r_record_address + 33'd1;
                n_bytes_left     = d_left;
                if (d_left == 16'd0) begin
                    n_phase = PH_OFFS;
                    n_count = 3'd0;
                    n_shift = '0;
                end
                n_emit    = d_emit;
                n_kind    = KIND_WRITE;
                n_address = d_a[31:0];
                n_length  = 16'd1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_wide           <= 1'b0;
            r_count          <= '0;
            r_shift          <= '0;
            r_record_address <= '0;
            r_bytes_left     <= '0;
            r_hit_ips        <= 1'b0;
            r_hit_ips32      <= 1'b0;
        end else if (in_fire) begin
            r_phase          <= n_phase;
            r_wide           <= n_wide;
            r_count          <= n_count;
            r_shift          <= n_shift;
            r_record_address <= n_record_address;
            r_bytes_left     <= n_bytes_left;
            r_hit_ips        <= n_hit_ips;
            r_hit_ips32      <= n_hit_ips32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_out_kind    <= n_kind;
            r_out_address <= n_address;
            r_out_length  <= n_length;
            r_out_data    <= (n_kind inside {KIND_WRITE, KIND_FILL}) ? i_patch_byte : 8'd0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_kind      = r_out_kind;
    assign o_write_address = r_out_address;
    assign o_write_length  = r_out_length;
    assign o_write_data    = r_out_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled without a waiting command");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_END || o_out_kind == KIND_REJECT)
        |-> o_write_address == 32'd0 && o_write_length == 16'd0 && o_write_data == 8'd0)
        else $error("status command carries payload");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_WRITE |-> o_write_length == 16'd1)
        else $error("byte write length not one");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == KIND_FILL |-> o_write_length != 16'd0)
        else $error("empty fill issued");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_emit && (n_kind == KIND_END || n_kind == KIND_REJECT)
        |=> r_phase == PH_IDLE)
        else $error("parser not idle after end or reject");

endmodule

>>> tb/sv/tb_ips_patch_stream_applier_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the IPS/IPS32 patch stream applier core.
module tb_ips_patch_stream_applier_core;
    import ipsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 450;
    localparam logic [39:0] MAGIC_IPS   = "PATCH";
    localparam logic [39:0] MAGIC_IPS32 = "IPS32";

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [15:0] len;
        logic [7:0]  data;
    } t_patch_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_patch_byte;
    logic        i_file_start;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_out_kind;
    logic [31:0] o_write_address;
    logic [15:0] o_write_length;
    logic [7:0]  o_write_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ips_patch_stream_applier_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_patch_byte    (i_patch_byte),
        .i_file_start    (i_file_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_kind      (o_out_kind),
        .o_write_address (o_write_address),
        .o_write_length  (o_write_length),
        .o_write_data    (o_write_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    t_patch_cmd expected_cmds[$];
    logic [8:0] pending_bytes[$];
    t_patch_cmd want_cmd;

    int err_count    = 0;
    int sent_items   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int rx_hold_len  = 0;
    int quiet_cycles = 0;

    logic [31:0] cfg_prot = '0;
    logic [31:0] cfg_lofs = '0;
    logic [31:0] cfg_msize = '0;

    logic [2:0]  pp_phase = PH_IDLE;
    logic        pp_wide = 1'b0;
    logic [2:0]  pp_count = '0;
    logic [31:0] pp_shift = '0;
    logic [63:0] pp_addr = '0;
    logic [15:0] pp_left = '0;
    logic        pp_hit_ips = 1'b0;
    logic        pp_hit_ips32 = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void start_record();
        pp_phase = PH_OFFS;
        pp_count = '0;
        pp_shift = '0;
    endfunction

    function automatic bit parse_patch_byte(input logic [7:0] b, input logic fs,
                                            output t_patch_cmd cmd);
        logic [63:0] lim;
        logic [63:0] o;
        logic [63:0] len;
        logic [63:0] a;
        logic [63:0] t;
        lim = {32'd0, cfg_msize};
        if (lim > {31'd0, ADDR_SPAN}) lim = {31'd0, ADDR_SPAN};
        cmd = '0;
        if (fs) begin
            pp_phase = PH_HEAD;
            pp_count = '0;
            pp_hit_ips = 1'b1;
            pp_hit_ips32 = 1'b1;
        end
        case (pp_phase)
            PH_HEAD: begin
                if (b != MAGIC_IPS[8*(4-pp_count) +: 8]) pp_hit_ips = 1'b0;
                if (b != MAGIC_IPS32[8*(4-pp_count) +: 8]) pp_hit_ips32 = 1'b0;
                pp_count = pp_count + 3'd1;
                if (pp_count < 3'd5) return 1'b0;
                if ((!pp_hit_ips && !pp_hit_ips32) || cfg_lofs > cfg_prot) begin
                    pp_phase = PH_IDLE;
                    cmd = {KIND_REJECT, 32'd0, 16'd0, 8'd0};
                    return 1'b1;
                end
                pp_wide = pp_hit_ips32;
                start_record();
                return 1'b0;
            end
            PH_OFFS: begin
                pp_shift = {pp_shift[23:0], b};
                pp_count = pp_count + 3'd1;
                if (pp_count < (pp_wide ? 3'd4 : 3'd3)) return 1'b0;
                if (pp_wide ? (pp_shift == TAIL_IPS32) : (pp_shift == TAIL_IPS)) begin
                    pp_phase = PH_IDLE;
                    cmd = {KIND_END, 32'd0, 16'd0, 8'd0};
                    return 1'b1;
                end
                pp_addr = {32'd0, pp_shift};
                pp_phase = PH_SIZE;
                pp_count = '0;
                pp_left = '0;
                return 1'b0;
            end
            PH_SIZE, PH_RLEN: begin
                pp_left = {pp_left[7:0], b};
                pp_count = pp_count + 3'd1;
                if (pp_count < 3'd2) return 1'b0;
                pp_count = '0;
                if (pp_phase == PH_RLEN) pp_phase = PH_RVAL;
                else pp_phase = (pp_left == 16'd0) ? PH_RLEN : PH_DATA;
                return 1'b0;
            end
            PH_RVAL: begin
                o = pp_addr;
                len = {48'd0, pp_left};
                start_record();
                if (o < cfg_prot) begin
                    if (o + len > cfg_prot) begin
                        len = len - ({32'd0, cfg_prot} - o);
                        o = {32'd0, cfg_prot};
                    end else begin
                        return 1'b0;
                    end
                end
                if (o < cfg_lofs) return 1'b0;
                a = o - cfg_lofs;
                if (a >= lim) return 1'b0;
                if (len > lim - a) len = lim - a;
                if (len == 64'd0) return 1'b0;
                cmd = {KIND_FILL, a[31:0], len[15:0], b};
                return 1'b1;
            end
            PH_DATA: begin
                t = pp_addr;
                pp_addr = pp_addr + 64'd1;
                pp_left = pp_left - 16'd1;
                if (pp_left == 16'd0) start_record();
                if (t < cfg_prot || t < cfg_lofs) return 1'b0;
                a = t - cfg_lofs;
                if (a >= lim) return 1'b0;
                cmd = {KIND_WRITE, a[31:0], 16'd1, b};
                return 1'b1;
            end
            default: begin
                pp_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("unexpected command kind", {30'd0, o_out_kind}, 32'd0);
            end else begin
                want_cmd = expected_cmds.pop_front();
                if (o_out_kind !== want_cmd.kind)
                    report_mismatch("kind", {30'd0, o_out_kind}, {30'd0, want_cmd.kind});
                if (o_write_address !== want_cmd.addr)
                    report_mismatch("address", o_write_address, want_cmd.addr);
                if (o_write_length !== want_cmd.len)
                    report_mismatch("length", {16'd0, o_write_length}, {16'd0, want_cmd.len});
                if (o_write_data !== want_cmd.data)
                    report_mismatch("data", {24'd0, o_write_data}, {24'd0, want_cmd.data});
            end
        end
    end

    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                i_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] timeout: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fs);
        t_patch_cmd cmd;
        i_valid <= 1'b1;
        i_patch_byte <= b;
        i_file_start <= fs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (fs || pp_phase != PH_IDLE) sent_items++;
        if (parse_patch_byte(b, fs, cmd)) expected_cmds.push_back(cmd);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_pending();
        logic [8:0] entry;
        while (pending_bytes.size() != 0) begin
            entry = pending_bytes.pop_front();
            send_byte(entry[7:0], entry[8]);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_PROTECTED_SIZE: cfg_prot = val;
            REG_LOAD_OFFSET:    cfg_lofs = val;
            default:            cfg_msize = val;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [31:0] prot, input logic [31:0] lofs,
                                input logic [31:0] msize);
        wait_drained();
        write_register(REG_PROTECTED_SIZE, prot);
        write_register(REG_LOAD_OFFSET, lofs);
        write_register(REG_MAPPED_SIZE, msize);
    endtask

    function automatic void push_byte(input logic [7:0] b, input logic fs);
        pending_bytes.push_back({fs, b});
    endfunction

    function automatic void push_u16(input logic [15:0] v);
        push_byte(v[15:8], 1'b0);
        push_byte(v[7:0], 1'b0);
    endfunction

    function automatic void push_header(input logic wide);
        logic [39:0] magic;
        magic = wide ? MAGIC_IPS32 : MAGIC_IPS;
        for (int i = 4; i >= 0; i--) push_byte(magic[8*i +: 8], i == 4);
    endfunction

    function automatic void push_bad_header(input logic wide);
        logic [39:0] magic;
        magic = wide ? MAGIC_IPS32 : MAGIC_IPS;
        if ($urandom_range(0, 1) == 0) magic = {$urandom, 8'($urandom)};
        else magic[$urandom_range(0, 39)] ^= 1'b1;
        for (int i = 4; i >= 0; i--) push_byte(magic[8*i +: 8], i == 4);
    endfunction

    function automatic void push_offset(input logic wide, input logic [31:0] ofs);
        if (wide) push_byte(ofs[31:24], 1'b0);
        push_byte(ofs[23:16], 1'b0);
        push_byte(ofs[15:8], 1'b0);
        push_byte(ofs[7:0], 1'b0);
    endfunction

    function automatic void push_tail(input logic wide);
        push_offset(wide, wide ? TAIL_IPS32 : TAIL_IPS);
    endfunction

    function automatic logic [31:0] pick_target(input logic wide);
        logic [31:0] base;
        case ($urandom_range(0, 5))
            0:       base = cfg_prot;
            1:       base = cfg_lofs;
            2:       base = cfg_lofs + cfg_msize;
            3:       base = 32'd0;
            4:       base = wide ? 32'hFFFF_FFF8 : 32'h00FF_FFF8;
            default: base = $urandom;
        endcase
        base = base + $urandom_range(0, 16) - 32'd8;
        if (!wide) base[31:24] = 8'h00;
        return base;
    endfunction

    function automatic void push_random_record(input logic wide);
        int n;
        push_offset(wide, pick_target(wide));
        if ($urandom_range(0, 3) == 0) begin
            push_u16(16'h0000);
            case ($urandom_range(0, 3))
                0:       push_u16(16'h0000);
                1:       push_u16(16'($urandom_range(1, 32)));
                2:       push_u16(16'hFFFF);
                default: push_u16(16'($urandom));
            endcase
            push_byte(8'($urandom), 1'b0);
        end else begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            push_u16(16'(n));
            repeat (n) push_byte(8'($urandom), 1'b0);
        end
    endfunction

    task automatic pick_random_config();
        logic [31:0] p;
        logic [31:0] l;
        logic [31:0] m;
        case ($urandom_range(0, 9))
            0: begin
                p = 32'd0; l = 32'd0; m = 32'hFFFF_FFFF;
            end
            1: begin
                p = 32'hFFFF_FFFF; l = 32'hFFFF_FFFF; m = 32'hFFFF_FFFF;
            end
            2: begin
                p = 32'd0; l = 32'd0; m = 32'd0;
            end
            3: begin
                p = $urandom_range(0, 255);
                l = p + $urandom_range(1, 64);
                m = $urandom_range(0, 1023);
            end
            4, 5, 6: begin
                p = $urandom_range(0, 767);
                l = $urandom_range(0, p);
                m = $urandom_range(1, 1023);
            end
            default: begin
                p = $urandom;
                l = $urandom_range(0, p);
                m = $urandom;
            end
        endcase
        apply_config(p, l, m);
    endtask

    task automatic test_directed_records();
        apply_config(32'h100, 32'h80, 32'h200);
        push_byte(8'hFF, 1'b0);
        push_header(1'b0);
        push_offset(1'b0, 32'h0000_00FF);
        push_u16(16'd2);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_offset(1'b0, 32'h0000_01F0);
        push_u16(16'h0000);
        push_u16(16'hFFFF);
        push_byte(8'h00, 1'b0);
        push_tail(1'b0);
        push_byte("I", 1'b1);
        push_byte("P", 1'b0);
        push_byte("S", 1'b0);
        push_byte("3", 1'b0);
        push_byte("3", 1'b0);
        send_pending();
        wait_drained();
    endtask

    task automatic test_config_change_midfile();
        apply_config(32'h40, 32'h20, 32'h1000);
        push_header(1'b1);
        push_offset(1'b1, 32'h38);
        push_u16(16'd16);
        repeat (16) push_byte(8'($urandom), 1'b0);
        send_pending();
        apply_config(32'h10, 32'h30, 32'h100);
        push_offset(1'b1, 32'h28);
        push_u16(16'd8);
        repeat (8) push_byte(8'($urandom), 1'b0);
        push_offset(1'b1, 32'h30);
        push_u16(16'h0000);
        push_u16(16'h0200);
        push_byte(8'($urandom), 1'b0);
        push_tail(1'b1);
        send_pending();
        wait_drained();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_config(32'd0, 32'd0, 32'hFFFF_FFFF);
        push_header(1'b1);
        push_offset(1'b1, 32'h10);
        push_u16(16'd48);
        repeat (48) push_byte(8'($urandom), 1'b0);
        push_tail(1'b1);
        rx_hold_len = 300;
        send_pending();
        wait_drained();
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        int stop_at;
        int pick;
        logic wide;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = sent_items + PHASE_ITEMS;
        while (sent_items < stop_at) begin
            if ($urandom_range(0, 4) == 0) pick_random_config();
            wide = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                push_header(wide);
                repeat ($urandom_range(1, 6)) push_random_record(wide);
                if (pick < 70) begin
                    push_tail(wide);
                end else begin
                    // cut the file short; the next file start aborts it
                    repeat ($urandom_range(1, pending_bytes.size() - 1))
                        pending_bytes.delete(pending_bytes.size() - 1);
                end
            end else if (pick < 88) begin
                push_bad_header(wide);
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
            end else begin
                push_header(wide);
                repeat ($urandom_range(4, 16)) push_byte(8'($urandom), 1'b0);
            end
            send_pending();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_patch_byte <= 8'h00;
        i_file_start <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_records();
        test_config_change_midfile();
        test_output_stall();
        run_random_phase(27, 78);
        run_random_phase(78, 27);
        run_random_phase(0, 0);
        wait_drained();

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
design/ipsa_pkg.sv
design/ips_patch_stream_applier_core.sv
tb/sv/tb_ips_patch_stream_applier_core.sv
